/* hdl/til_pkg.sv */
package til_pkg;

   // Default sizing of the node pool and the alphabet
   localparam int NODE_COUNT_DEF = 1024;
   localparam int ALPHABET_DEF   = 26;

   // Fixed field widths
   localparam int LETTER_W = 5;
   // Wide enough to hold any legal ALPHABET value for the range compare
   localparam int LETTER_CMP_W = 9;

   // Operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // Result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Access strobes from the walk controller to the node store
   typedef struct packed {
      logic child_re;
      logic child_we;
      logic wend_re;
      logic wend_we;
   } store_ctl_type;

endpackage

/* hdl/til_store.sv */
module til_store #(
   parameter int NODE_COUNT = til_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET   = til_pkg::ALPHABET_DEF,
   parameter int NODE_W     = $clog2(NODE_COUNT),
   parameter int ADDR_W     = $clog2(NODE_COUNT * ALPHABET)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  til_pkg::store_ctl_type ctl,
   input  logic [ADDR_W-1:0]      child_addr,
   input  logic [NODE_W-1:0]      child_wdata,
   output logic [NODE_W-1:0]      child_rdata,
   input  logic [NODE_W-1:0]      wend_addr,
   output logic                   wend_rdata,
   output logic                   clear_busy
);
   import til_pkg::*;

   localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET;

   logic [NODE_W-1:0] child_mem [CHILD_DEPTH];
   logic              wend_mem  [NODE_COUNT];

   logic [ADDR_W-1:0] sweep_ff;
   logic [ADDR_W-1:0] sweep_in;
   logic              busy_ff;
   logic              busy_in;
   logic [NODE_W-1:0] child_rdata_ff;
   logic              wend_rdata_ff;
   logic              sweep_in_wend;

   // Clearing pass after reset: one child slot per cycle
   always_comb begin
      sweep_in = sweep_ff;
      busy_in  = busy_ff;
      if (busy_ff) begin
         sweep_in = sweep_ff + ADDR_W'(1);
         if (sweep_ff == ADDR_W'(CHILD_DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   assign sweep_in_wend = (sweep_ff < ADDR_W'(NODE_COUNT));

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         busy_ff  <= 1'b1;
      end else begin
         sweep_ff <= sweep_in;
         busy_ff  <= busy_in;
      end
   end

   // Child table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         child_mem[sweep_ff] <= '0;
      end else if (ctl.child_we) begin
         child_mem[child_addr] <= child_wdata;
      end
      if (ctl.child_re) begin
         child_rdata_ff <= child_mem[child_addr];
      end
   end

   // Word-end marks, cleared alongside the first NODE_COUNT sweep steps
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         if (sweep_in_wend) begin
            wend_mem[sweep_ff[NODE_W-1:0]] <= 1'b0;
         end
      end else if (ctl.wend_we) begin
         wend_mem[wend_addr] <= 1'b1;
      end
      if (ctl.wend_re) begin
         wend_rdata_ff <= wend_mem[wend_addr];
      end
   end

   assign child_rdata = child_rdata_ff;
   assign wend_rdata  = wend_rdata_ff;
   assign clear_busy  = busy_ff;

endmodule

/* hdl/trie_insert_lookup.sv */
// Letter trie with insert and query, fed one letter per transaction.
// Request channel (req_valid/req_stall): operation, letter and last mark of
// one letter. Words are sent letter by letter; each letter carries its own
// operation bit. Response channel (rsp_valid/rsp_stall): one transaction
// per word, on its last letter, with found and status.
// A letter that walks the trie passes through ST_LOOKUP, where the
// child-table read for the current node returns from its registered read
// port; a letter after a miss or overflow skips the read. A last letter
// also passes ST_FINISH (word-end access) and ST_REPORT (result load).
// req_stall is high outside ST_IDLE, so no letter is taken while one is busy.
// Reset: a clearing pass over the NODE_COUNT*ALPHABET child slots (26624 by
// default) zeroes the child table and word-end marks; req_stall stays high
// until it finishes. The pool then holds only the root.
// Receiver stall: the result waits in the output register; the next letters
// are still taken, and a further result waits until the register frees up.
module trie_insert_lookup #(
   parameter int NODE_COUNT = til_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET   = til_pkg::ALPHABET_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic [til_pkg::LETTER_W-1:0] req_letter,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_found,
   output logic                         rsp_status
);
   import til_pkg::*;

   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int ADDR_W = $clog2(NODE_COUNT * ALPHABET);
   localparam int USED_W = $clog2(NODE_COUNT + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_FINISH,
      ST_REPORT
   } state_type;

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] cursor_ff, cursor_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic              miss_ff, miss_in;
   logic              ovf_ff, ovf_in;
   logic              op_ff, op_in;
   logic              last_ff, last_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_status_ff, rsp_status_in;

   store_ctl_type     ctl;
   logic [ADDR_W-1:0] child_addr;
   logic [NODE_W-1:0] child_wdata;
   logic [NODE_W-1:0] child_rdata;
   logic              wend_rdata;
   logic              clear_busy;
   logic [ADDR_W-1:0] slot_calc;
   logic              letter_ok;
   logic              walk_ok;

   til_store #(
      .NODE_COUNT (NODE_COUNT),
      .ALPHABET   (ALPHABET),
      .NODE_W     (NODE_W),
      .ADDR_W     (ADDR_W)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .child_addr  (child_addr),
      .child_wdata (child_wdata),
      .child_rdata (child_rdata),
      .wend_addr   (cursor_ff),
      .wend_rdata  (wend_rdata),
      .clear_busy  (clear_busy)
   );

   // Slot of the incoming letter under the current node
   assign slot_calc = ADDR_W'(cursor_ff) * ADDR_W'(ALPHABET) + ADDR_W'(req_letter);
   assign letter_ok = (LETTER_CMP_W'(req_letter) < LETTER_CMP_W'(ALPHABET));
   assign walk_ok   = !miss_ff && !ovf_ff;

   assign req_stall = (state_ff != ST_IDLE) || clear_busy;

   // Walk controller
   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      used_in       = used_ff;
      miss_in       = miss_ff;
      ovf_in        = ovf_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      slot_in       = slot_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ctl           = '0;
      child_addr    = slot_ff;
      child_wdata   = NODE_W'(used_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !clear_busy) begin
               op_in   = req_operation;
               last_in = req_last;
               slot_in = slot_calc;
               if (walk_ok && letter_ok) begin
                  // start the child read for this letter
                  ctl.child_re = 1'b1;
                  child_addr   = slot_calc;
                  state_in     = ST_LOOKUP;
               end else begin
                  if (walk_ok) begin
                     miss_in = 1'b1;
                  end
                  state_in = req_last ? ST_FINISH : ST_IDLE;
               end
            end
         end
         ST_LOOKUP: begin
            if (child_rdata == '0) begin
               if (op_ff == OP_QUERY) begin
                  miss_in = 1'b1;
               end else if (used_ff < USED_W'(NODE_COUNT)) begin
                  // allocate the next pool node as the child
                  ctl.child_we = 1'b1;
                  cursor_in    = NODE_W'(used_ff);
                  used_in      = used_ff + USED_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end else begin
               cursor_in = child_rdata;
            end
            state_in = last_ff ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (op_ff == OP_QUERY) begin
               ctl.wend_re = 1'b1;
            end else if (walk_ok) begin
               ctl.wend_we = 1'b1;
            end
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = (op_ff == OP_QUERY) ? (walk_ok && wend_rdata) : walk_ok;
               rsp_status_in = (op_ff == OP_INSERT && ovf_ff) ? STATUS_FULL : STATUS_OK;
               cursor_in     = '0;
               miss_in       = 1'b0;
               ovf_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      last_ff       <= last_in;
      slot_ff       <= slot_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         used_ff      <= USED_W'(1);
         miss_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         used_ff      <= used_in;
         miss_ff      <= miss_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;

   // No transaction is taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> req_stall)
      else $error("request accepted during clearing pass");

   // The pool count never passes the pool size
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(NODE_COUNT))
      else $error("node pool count out of range");

   // A child slot is only written when the lookup found it empty
   a_alloc_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.child_we |-> (state_ff == ST_LOOKUP && child_rdata == '0))
      else $error("child slot overwritten");

   // A failed insert never reports the word as marked
   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> !rsp_found)
      else $error("full status with found set");

   // A new result is loaded only from the report state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_REPORT))
      else $error("result loaded outside report state");

endmodule
